// ----- hw/rtl/sat_pkg.sv -----
// ----------------------------------------------------------------------------
// sat_pkg
// Shared widths, codes and controller/datapath interface types for the
// sorted array table.
// ----------------------------------------------------------------------------
package sat_pkg;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int POS_W      = 6;
    localparam int PROBES_W   = 3;
    localparam int ENTRIES_W  = 7;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // Datapath micro-operations
    localparam int UOP_W = 4;
    localparam logic [UOP_W-1:0] UOP_NONE      = 4'd0;
    localparam logic [UOP_W-1:0] UOP_LOAD      = 4'd1;   // latch word, init indices
    localparam logic [UOP_W-1:0] UOP_INS_RD    = 4'd2;   // read entry below idx
    localparam logic [UOP_W-1:0] UOP_INS_SHIFT = 4'd3;   // move read entry up, idx--
    localparam logic [UOP_W-1:0] UOP_INS_PUT   = 4'd4;   // store value at idx, fill++
    localparam logic [UOP_W-1:0] UOP_RD_IDX    = 4'd5;   // read entry at idx
    localparam logic [UOP_W-1:0] UOP_DEL_NEXT  = 4'd6;   // idx++
    localparam logic [UOP_W-1:0] UOP_DEL_HIT   = 4'd7;   // pos = idx, idx++
    localparam logic [UOP_W-1:0] UOP_SH_MOVE   = 4'd8;   // move read entry down, idx++
    localparam logic [UOP_W-1:0] UOP_SH_END    = 4'd9;   // fill--
    localparam logic [UOP_W-1:0] UOP_SR_RD     = 4'd10;  // read midpoint, count probe
    localparam logic [UOP_W-1:0] UOP_SR_LO     = 4'd11;  // lo = mid + 1
    localparam logic [UOP_W-1:0] UOP_SR_HI     = 4'd12;  // hi = mid
    localparam logic [UOP_W-1:0] UOP_SR_HIT    = 4'd13;  // pos = mid

    typedef struct packed {
        logic [UOP_W-1:0]    uop;
        logic                stat_we;
        logic [STATUS_W-1:0] stat;
        logic                out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             full;      // fill at capacity
        logic             idx_zero;  // idx == 0
        logic             idx_end;   // idx == fill
        logic             sr_empty;  // search window empty
        logic             eq;        // read entry == value
        logic             gt;        // read entry > value
        logic             out_free;  // output register can take a word
    } t_dp_sts;

endpackage

// ----- hw/rtl/sorted_array_table_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_array_table_unit
// Ascending table of signed 32-bit values with insert, delete and binary
// search commands; one result word per command word.
// ----------------------------------------------------------------------------
//
//  Channel   | Dir | Word contents (lowest bit first)
//  ----------+-----+-------------------------------------------------------
//  s_axis    | in  | tuser: cmd[1:0]; tdata: value[31:0] (signed)
//  m_axis    | out | tuser: status[1:0];
//            |     | tdata: position[5:0], probes[8:6], entries[15:9]
//
//  One command at a time. The table sits in a single-port-write, registered
//  read memory, so every table access is a read followed by an act on the
//  registered entry. Steps per command:
//    insert: compare entries from the top down, moving each larger one up,
//            then store the value (a full table is refused with FULL)
//    delete: scan up to the hit or the fill count (miss); on a hit, move the tail down
//    search: probe the window midpoint until a hit or an empty window,
//            with at most log2(fill) + 1 probes
//  A finished word waits in the output register while m_axis_tready is low;
//  the sequencer holds in its last state until that register frees up, so
//  an output stall holds off the next command. Once the word moves into the
//  output register, the next command is taken.
//  Reset empties the table (fill count to zero); memory contents are not
//  cleared since entries at or above the fill count are never read.
//
module sorted_array_table_unit #(
    parameter int DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sat_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // value[31:0]
    input  logic [sat_pkg::CMD_W-1:0]       s_axis_tuser,   // cmd[1:0]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [sat_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // position, probes, entries
    output logic [sat_pkg::STATUS_W-1:0]    m_axis_tuser    // status[1:0]
);
    import sat_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer: take a word only when idle, then step through the command.
    sat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Table memory, indices and the output register.
    sat_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_op     (s_axis_tuser),
        .i_value      (s_axis_tdata[VALUE_W-1:0]),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_data   (m_axis_tdata),
        .o_out_status (m_axis_tuser)
    );

endmodule

// ----- hw/rtl/sat_ctrl.sv -----
// ----------------------------------------------------------------------------
// sat_ctrl
// Command sequencer: walks insert, delete and search through the datapath.
// ----------------------------------------------------------------------------
module sat_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  sat_pkg::t_dp_sts i_sts,
    output sat_pkg::t_dp_cmd o_cmd
);
    import sat_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DEC     = 4'd1;
    localparam logic [3:0] S_INS_RD  = 4'd2;
    localparam logic [3:0] S_INS_CMP = 4'd3;
    localparam logic [3:0] S_DEL_RD  = 4'd4;
    localparam logic [3:0] S_DEL_CMP = 4'd5;
    localparam logic [3:0] S_SH_RD   = 4'd6;
    localparam logic [3:0] S_SH_WR   = 4'd7;
    localparam logic [3:0] S_SR_RD   = 4'd8;
    localparam logic [3:0] S_SR_CMP  = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.uop      = UOP_NONE;
        o_cmd.stat_we  = 1'b0;
        o_cmd.stat     = ST_OK;
        o_cmd.out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.uop = UOP_LOAD;
                    n_state   = S_DEC;
                end
            end
            S_DEC: begin
                case (i_sts.op)
                    CMD_INSERT: begin
                        if (i_sts.full) begin
                            o_cmd.stat_we = 1'b1;
                            o_cmd.stat    = ST_FULL;
                            n_state       = S_DONE;
                        end else begin
                            n_state = S_INS_RD;
                        end
                    end
                    CMD_DELETE: n_state = S_DEL_RD;
                    CMD_SEARCH: n_state = S_SR_RD;
                    default: begin
                        o_cmd.stat_we = 1'b1;
                        o_cmd.stat    = ST_MISS;
                        n_state       = S_DONE;
                    end
                endcase
            end
            S_INS_RD: begin
                if (i_sts.idx_zero) begin
                    o_cmd.uop     = UOP_INS_PUT;
                    o_cmd.stat_we = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.uop = UOP_INS_RD;
                    n_state   = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_sts.gt) begin
                    o_cmd.uop = UOP_INS_SHIFT;
                    n_state   = S_INS_RD;
                end else begin
                    o_cmd.uop     = UOP_INS_PUT;
                    o_cmd.stat_we = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_DEL_RD: begin
                if (i_sts.idx_end) begin
                    o_cmd.stat_we = 1'b1;
                    o_cmd.stat    = ST_MISS;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.uop = UOP_RD_IDX;
                    n_state   = S_DEL_CMP;
                end
            end
            S_DEL_CMP: begin
                if (i_sts.eq) begin
                    o_cmd.uop = UOP_DEL_HIT;
                    n_state   = S_SH_RD;
                end else begin
                    o_cmd.uop = UOP_DEL_NEXT;
                    n_state   = S_DEL_RD;
                end
            end
            S_SH_RD: begin
                if (i_sts.idx_end) begin
                    o_cmd.uop     = UOP_SH_END;
                    o_cmd.stat_we = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.uop = UOP_RD_IDX;
                    n_state   = S_SH_WR;
                end
            end
            S_SH_WR: begin
                o_cmd.uop = UOP_SH_MOVE;
                n_state   = S_SH_RD;
            end
            S_SR_RD: begin
                if (i_sts.sr_empty) begin
                    o_cmd.stat_we = 1'b1;
                    o_cmd.stat    = ST_MISS;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.uop = UOP_SR_RD;
                    n_state   = S_SR_CMP;
                end
            end
            S_SR_CMP: begin
                if (i_sts.eq) begin
                    o_cmd.uop     = UOP_SR_HIT;
                    o_cmd.stat_we = 1'b1;
                    n_state       = S_DONE;
                end else if (i_sts.gt) begin
                    o_cmd.uop = UOP_SR_HI;
                    n_state   = S_SR_RD;
                end else begin
                    o_cmd.uop = UOP_SR_LO;
                    n_state   = S_SR_RD;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- hw/rtl/sat_datapath.sv -----
// ----------------------------------------------------------------------------
// sat_datapath
// Table memory, fill count, index registers, compare and output register.
// ----------------------------------------------------------------------------
module sat_datapath #(
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [sat_pkg::CMD_W-1:0]        i_cmd_op,
    input  logic [sat_pkg::VALUE_W-1:0]      i_value,
    input  sat_pkg::t_dp_cmd                 i_cmd,
    output sat_pkg::t_dp_sts                 o_sts,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [sat_pkg::OUT_DATA_W-1:0]   o_out_data,
    output logic [sat_pkg::STATUS_W-1:0]     o_out_status
);
    import sat_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    logic signed [VALUE_W-1:0] mem [DEPTH];

    logic [CMD_W-1:0]          r_op;
    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] r_rdata;
    logic [FW-1:0]             r_fill;
    logic [FW-1:0]             r_idx;
    logic [FW-1:0]             r_lo;
    logic [FW-1:0]             r_hi;
    logic [FW-1:0]             r_mid;
    logic [FW-1:0]             r_cnt;
    logic [FW-1:0]             r_pos;
    logic [STATUS_W-1:0]       r_stat;
    logic                      r_out_valid;
    logic [OUT_DATA_W-1:0]     r_out_data;
    logic [STATUS_W-1:0]       r_out_status;

    logic [FW-1:0]             w_idx_m1;
    logic [FW:0]               w_sum;
    logic [FW-1:0]             w_mid;
    logic                      w_re;
    logic [AW-1:0]             w_raddr;
    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    logic signed [VALUE_W-1:0] w_wdata;

    assign w_idx_m1 = r_idx - FW'(1);
    // floor midpoint of the inclusive window [lo, hi-1]
    assign w_sum    = {1'b0, r_lo} + {1'b0, r_hi} - (FW + 1)'(1);
    assign w_mid    = w_sum[FW:1];

    always_comb begin
        w_re    = 1'b0;
        w_raddr = r_idx[AW-1:0];
        w_we    = 1'b0;
        w_waddr = r_idx[AW-1:0];
        w_wdata = r_rdata;
        case (i_cmd.uop)
            UOP_INS_RD: begin
                w_re    = 1'b1;
                w_raddr = w_idx_m1[AW-1:0];
            end
            UOP_RD_IDX: w_re = 1'b1;
            UOP_SR_RD: begin
                w_re    = 1'b1;
                w_raddr = w_mid[AW-1:0];
            end
            UOP_INS_SHIFT: w_we = 1'b1;
            UOP_INS_PUT: begin
                w_we    = 1'b1;
                w_wdata = r_value;
            end
            UOP_SH_MOVE: begin
                w_we    = 1'b1;
                w_waddr = w_idx_m1[AW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    // control state: fill count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.uop)
                UOP_INS_PUT: r_fill <= r_fill + FW'(1);
                UOP_SH_END:  r_fill <= r_fill - FW'(1);
                default: ;
            endcase
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.uop)
            UOP_LOAD: begin
                r_op    <= i_cmd_op;
                r_value <= i_value;
                r_idx   <= (i_cmd_op == CMD_INSERT) ? r_fill : '0;
                r_lo    <= '0;
                r_hi    <= r_fill;
                r_cnt   <= '0;
                r_pos   <= '0;
            end
            UOP_INS_SHIFT: r_idx <= w_idx_m1;
            UOP_INS_PUT:   r_pos <= r_idx;
            UOP_DEL_NEXT:  r_idx <= r_idx + FW'(1);
            UOP_DEL_HIT: begin
                r_pos <= r_idx;
                r_idx <= r_idx + FW'(1);
            end
            UOP_SH_MOVE:   r_idx <= r_idx + FW'(1);
            UOP_SR_RD: begin
                r_mid <= w_mid;
                r_cnt <= r_cnt + FW'(1);
            end
            UOP_SR_LO:     r_lo  <= r_mid + FW'(1);
            UOP_SR_HI:     r_hi  <= r_mid;
            UOP_SR_HIT:    r_pos <= r_mid;
            default: ;
        endcase
        if (i_cmd.stat_we) begin
            r_stat <= i_cmd.stat;
        end
        if (i_cmd.out_load) begin
            r_out_data   <= {ENTRIES_W'(r_fill), PROBES_W'(r_cnt), POS_W'(r_pos)};
            r_out_status <= r_stat;
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.full     = (r_fill == FW'(DEPTH));
    assign o_sts.idx_zero = (r_idx == '0);
    assign o_sts.idx_end  = (r_idx == r_fill);
    assign o_sts.sr_empty = (r_lo >= r_hi);
    assign o_sts.eq       = (r_rdata == r_value);
    assign o_sts.gt       = (r_rdata > r_value);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out_data;
    assign o_out_status = r_out_status;

endmodule
